>>> rtl/core/dvtu_pkg.sv
// ----------------------------------------------------------------------------
// dvtu_pkg
// Shared constants, types and helpers for the distance vector table update.
// ----------------------------------------------------------------------------
package dvtu_pkg;

  localparam int DEPTH   = 32;
  localparam int ID_BITS = 32;

  // Ids arrive on 32-bit ports, so at most 32 bits are ever stored.
  localparam int ID_W    = (ID_BITS < 32) ? ID_BITS : 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DIST_W  = 8;
  localparam int OIDX_W  = 5;
  localparam int ACT_W   = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAME_HOP = 3'd0,
    ACT_IMPROVED = 3'd1,
    ACT_KEPT     = 3'd2,
    ACT_INSERTED = 3'd3,
    ACT_FULL     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   dest;
    logic [ID_W-1:0]   hop;
    logic [DIST_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    action_t           action;
    logic [OIDX_W-1:0] index;
    logic [DIST_W-1:0] distance;
  } result_t;

  // Slot number as reported on the result port: its low five bits.
  function automatic logic [OIDX_W-1:0] out_index(input logic [CNT_W-1:0] slot);
    logic [CNT_W+OIDX_W-1:0] wide;
    wide = {{OIDX_W{1'b0}}, slot};
    return wide[OIDX_W-1:0];
  endfunction

endpackage

>>> rtl/core/distance_vector_table_update_top.sv
// An advertised route (destination, next hop, distance) is taken when the
// block is idle and yields exactly one result: same hop replaced, improved,
// kept, inserted, or table full. The table is scanned one slot per cycle
// through a single registered read port and one shared id comparator, and
// the scan stops once a match is found or all filled slots are passed, so
// at most DEPTH slots (32) are read for one item. The result sits in an
// output register, so the next request is taken while a result waits to
// be read out.
// ----------------------------------------------------------------------------
// distance_vector_table_update_top
// Distance vector routing table update with a sequential table scan.
// ----------------------------------------------------------------------------
module distance_vector_table_update_top
  import dvtu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_dest_net,
  input  logic [31:0]       in_next_hop,
  input  logic [DIST_W-1:0] in_route_distance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ACT_W-1:0]  out_action,
  output logic [OIDX_W-1:0] out_entry_index,
  output logic [DIST_W-1:0] out_stored_distance
);

  rd_req_t rd;
  wr_req_t wr;
  entry_t  rd_data;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  dvtu_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  dvtu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_dest  (in_dest_net[ID_W-1:0]),
    .req_hop   (in_next_hop[ID_W-1:0]),
    .req_dist  (in_route_distance),
    .rd        (rd),
    .wr        (wr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = out_res_r.action;
  assign out_entry_index     = out_res_r.index;
  assign out_stored_distance = out_res_r.distance;

`ifndef SYNTH
  // A taken request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in progress");

  // A full table reports neither a slot nor a distance.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_FULL |->
      out_entry_index == '0 && out_stored_distance == '0)
    else $error("table full result carries nonzero fields");

  // Only defined result codes leave the block.
  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_action == ACT_SAME_HOP || out_action == ACT_IMPROVED ||
      out_action == ACT_KEPT || out_action == ACT_INSERTED ||
      out_action == ACT_FULL)
    else $error("undefined action code on result");

  // Nothing is written to the table while the block waits for a request.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !wr.en)
    else $error("table written while idle");
`endif

endmodule

>>> rtl/core/dvtu_table.sv
// ----------------------------------------------------------------------------
// dvtu_table
// Routing table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dvtu_table
  import dvtu_pkg::*;
(
  input  logic    clk,
  input  wr_req_t wr,
  input  rd_req_t rd,
  output entry_t  rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/dvtu_seq.sv
// ----------------------------------------------------------------------------
// dvtu_seq
// Sequencer that scans the table with one shared id comparator and then
// updates or keeps the matching entry, inserts a new one or reports a full table.
// ----------------------------------------------------------------------------
module dvtu_seq
  import dvtu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [ID_W-1:0]   req_dest,
  input  logic [ID_W-1:0]   req_hop,
  input  logic [DIST_W-1:0] req_dist,
  output rd_req_t           rd,
  output wr_req_t           wr,
  input  entry_t            rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              found_r, found_nxt;
  logic [ID_W-1:0]   dest_r, dest_nxt;
  logic [ID_W-1:0]   hop_r, hop_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  result_t           res_r, res_nxt;

  logic [ID_W-1:0]   cmp_a, cmp_b;
  logic              cmp_eq;
  logic [CNT_W-1:0]  idx_inc;

  // The one comparator looks at destinations while scanning and at next
  // hops once the matching entry is held on the read port.
  always_comb begin
    if (state_r == ST_DECIDE) begin
      cmp_a = rd_data.hop;
      cmp_b = hop_r;
    end else begin
      cmp_a = rd_data.dest;
      cmp_b = dest_r;
    end
    cmp_eq = (cmp_a == cmp_b);
  end

  assign idx_inc = CNT_W'(idx_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    dest_r  <= dest_nxt;
    hop_r   <= hop_nxt;
    dist_r  <= dist_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    count_nxt         = count_r;
    found_nxt         = found_r;
    dest_nxt          = dest_r;
    hop_nxt           = hop_r;
    dist_nxt          = dist_r;
    res_nxt           = res_r;
    req_ready         = 1'b0;
    res_valid         = 1'b0;
    rd.en             = 1'b0;
    rd.addr           = '0;
    wr.en             = 1'b0;
    wr.addr           = idx_r;
    wr.entry.dest     = dest_r;
    wr.entry.hop      = hop_r;
    wr.entry.distance = dist_r;

    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          dest_nxt  = req_dest;
          hop_nxt   = req_hop;
          dist_nxt  = req_dist;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          if (count_r == '0) begin
            state_nxt = ST_DECIDE;
          end else begin
            rd.en     = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Read data belongs to slot idx_r; the next slot is fetched meanwhile unless the scan ends.
        if (cmp_eq) begin
          found_nxt = 1'b1;
          state_nxt = ST_DECIDE;
        end else if (idx_inc == count_r) begin
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt = idx_inc[IDX_W-1:0];
          rd.en   = 1'b1;
          rd.addr = idx_inc[IDX_W-1:0];
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_DONE;
        if (found_r) begin
          res_nxt.index = out_index(CNT_W'(idx_r));
          if (cmp_eq) begin
            wr.en            = 1'b1;
            res_nxt.action   = ACT_SAME_HOP;
            res_nxt.distance = dist_r;
          end else if (dist_r < rd_data.distance) begin
            wr.en            = 1'b1;
            res_nxt.action   = ACT_IMPROVED;
            res_nxt.distance = dist_r;
          end else begin
            res_nxt.action   = ACT_KEPT;
            res_nxt.distance = rd_data.distance;
          end
        end else if (count_r < CNT_W'(DEPTH)) begin
          wr.en            = 1'b1;
          wr.addr          = count_r[IDX_W-1:0];
          count_nxt        = count_r + CNT_W'(1);
          res_nxt.action   = ACT_INSERTED;
          res_nxt.index    = out_index(count_r);
          res_nxt.distance = dist_r;
        end else begin
          res_nxt.action   = ACT_FULL;
          res_nxt.index    = '0;
          res_nxt.distance = '0;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the distance vector table update block.
// A short table of directed routes is followed by random route requests,
// mostly re-advertisements of routes already in the table. Every result is
// compared with its typed expectation or with a shadow routing table kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  import dvtu_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PAUSE_EVERY  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [31:0]       dest;
    logic [31:0]       hop;
    logic [DIST_W-1:0] distance;
    bit                typed;
    result_t           want;
  } route_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [31:0]       in_dest_net = '0;
  logic [31:0]       in_next_hop = '0;
  logic [DIST_W-1:0] in_route_distance = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ACT_W-1:0]  out_action;
  logic [OIDX_W-1:0] out_entry_index;
  logic [DIST_W-1:0] out_stored_distance;

  // Typed-in expectation that travels with the request currently offered.
  bit                drv_typed = 1'b0;
  result_t           drv_want = '0;

  // Shadow routing table.
  bit                shadow_valid [DEPTH];
  logic [ID_W-1:0]   shadow_dest  [DEPTH];
  logic [ID_W-1:0]   shadow_hop   [DEPTH];
  logic [DIST_W-1:0] shadow_dist  [DEPTH];
  int                shadow_count = 0;

  result_t           pending_results [$];
  route_row_t        directed_routes [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                calm_left = 0;
  logic [31:0]       hop_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                      32'h8000_0000};

  distance_vector_table_update_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_dest_net         (in_dest_net),
    .in_next_hop         (in_next_hop),
    .in_route_distance   (in_route_distance),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_action          (out_action),
    .out_entry_index     (out_entry_index),
    .out_stored_distance (out_stored_distance)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one advertised route to the shadow table and returns the result.
  function automatic result_t route_table_update(input logic [31:0] dest_in,
                                                 input logic [31:0] hop_in,
                                                 input logic [DIST_W-1:0] dist_in);
    logic [ID_W-1:0] dest;
    logic [ID_W-1:0] hop;
    int              slot;
    bit              found;
    result_t         r;
    dest  = dest_in[ID_W-1:0];
    hop   = hop_in[ID_W-1:0];
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!found && shadow_valid[i] && shadow_dest[i] == dest) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      if (shadow_hop[slot] == hop) begin
        shadow_dist[slot] = dist_in;
        r.action = ACT_SAME_HOP;
      end else if (dist_in < shadow_dist[slot]) begin
        shadow_hop[slot]  = hop;
        shadow_dist[slot] = dist_in;
        r.action = ACT_IMPROVED;
      end else begin
        r.action = ACT_KEPT;
      end
      r.index    = OIDX_W'(slot);
      r.distance = shadow_dist[slot];
    end else if (shadow_count < DEPTH) begin
      slot = shadow_count;
      shadow_valid[slot] = 1'b1;
      shadow_dest[slot]  = dest;
      shadow_hop[slot]   = hop;
      shadow_dist[slot]  = dist_in;
      shadow_count++;
      r.action   = ACT_INSERTED;
      r.index    = OIDX_W'(slot);
      r.distance = dist_in;
    end else begin
      r.action   = ACT_FULL;
      r.index    = '0;
      r.distance = '0;
    end
    return r;
  endfunction

  // Sender gap: mostly none or short, a few long, and now and then a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_route(input logic [31:0] dest, input logic [31:0] hop,
                           input logic [DIST_W-1:0] route_dist, input bit typed,
                           input action_t act, input logic [OIDX_W-1:0] idx,
                           input logic [DIST_W-1:0] want_dist);
    route_row_t row;
    row.dest          = dest;
    row.hop           = hop;
    row.distance      = route_dist;
    row.typed         = typed;
    row.want.action   = act;
    row.want.index    = idx;
    row.want.distance = want_dist;
    directed_routes.push_back(row);
  endtask

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high into the next request when no gap is drawn.
  task automatic send_route(input logic [31:0] dest, input logic [31:0] hop,
                            input logic [DIST_W-1:0] route_dist, input bit typed,
                            input result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_dest_net       <= dest;
    in_next_hop       <= hop;
    in_route_distance <= route_dist;
    drv_typed         <= typed;
    drv_want          <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Predict at the edge where a request is accepted.
  always @(posedge clk) begin : accept_side
    result_t predicted;
    if (rst_n && in_valid && in_ready) begin
      predicted = route_table_update(in_dest_net, in_next_hop, in_route_distance);
      pending_results.push_back(drv_typed ? drv_want : predicted);
    end
  end

  always @(posedge clk) begin : result_side
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, action %0d index %0d distance %0d", $time,
                 out_action, out_entry_index, out_stored_distance);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_action !== want.action) begin
          $display("%0t: action expected %0d, actual %0d", $time, want.action, out_action);
          mismatches++;
        end
        if (out_entry_index !== want.index) begin
          $display("%0t: entry_index expected %0d, actual %0d", $time, want.index,
                   out_entry_index);
          mismatches++;
        end
        if (out_stored_distance !== want.distance) begin
          $display("%0t: stored_distance expected %0d, actual %0d", $time, want.distance,
                   out_stored_distance);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    @(posedge clk);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: ready bursts with stalls, mostly short and a few long.
  initial begin : receiver
    int on_len;
    int off_len;
    int r;
    forever begin
      r = $urandom_range(0, 99);
      on_len = (r < 10) ? $urandom_range(50, 150) : $urandom_range(1, 5);
      out_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 60) off_len = $urandom_range(1, 2);
      else if (r < 95) off_len = $urandom_range(3, 10);
      else off_len = $urandom_range(20, 60);
      out_ready <= 1'b0;
      repeat (off_len) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0]       r_dest;
    logic [31:0]       r_hop;
    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] base;
    int                slot;
    int                mode;

    // Directed routes on an empty table; typed rows can be read off directly.
    add_route(32'h0000_0000, 32'h0000_0000, 8'd0,   1, ACT_INSERTED, 5'd0, 8'd0);
    add_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1, ACT_INSERTED, 5'd1, 8'd255);
    add_route(32'h0000_0000, 32'h0000_0000, 8'd255, 1, ACT_SAME_HOP, 5'd0, 8'd255);
    // Equal distance through another hop keeps the old route.
    add_route(32'h0000_0000, 32'h0000_0001, 8'd255, 1, ACT_KEPT,     5'd0, 8'd255);
    add_route(32'h0000_0000, 32'h0000_0001, 8'd254, 1, ACT_IMPROVED, 5'd0, 8'd254);
    add_route(32'h0000_0000, 32'h0000_0000, 8'd254, 1, ACT_KEPT,     5'd0, 8'd254);
    add_route(32'hFFFF_FFFF, 32'h0000_0000, 8'd0,   1, ACT_IMPROVED, 5'd1, 8'd0);
    add_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0,   1, ACT_KEPT,     5'd1, 8'd0);
    // A worse distance on the same hop is still taken.
    add_route(32'hFFFF_FFFF, 32'h0000_0000, 8'd255, 1, ACT_SAME_HOP, 5'd1, 8'd255);
    add_route(32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h55,  1, ACT_INSERTED, 5'd2, 8'h55);
    add_route(32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'hAA,  1, ACT_INSERTED, 5'd3, 8'hAA);
    add_route(32'hA5A5_A5A5, 32'h1234_5678, 8'h56,  1, ACT_KEPT,     5'd2, 8'h55);
    add_route(32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'h01,  1, ACT_SAME_HOP, 5'd3, 8'h01);
    add_route(32'h0000_0001, 32'h0000_0002, 8'd16,  0, ACT_SAME_HOP, 5'd0, 8'd0);
    add_route(32'h8000_0000, 32'h0000_0001, 8'h80,  0, ACT_SAME_HOP, 5'd0, 8'd0);
    add_route(32'h0000_0001, 32'h0000_0003, 8'd15,  0, ACT_SAME_HOP, 5'd0, 8'd0);
    add_route(32'h8000_0000, 32'h7FFF_FFFF, 8'h7F,  0, ACT_SAME_HOP, 5'd0, 8'd0);
    add_route(32'h7FFF_FFFF, 32'h8000_0000, 8'd1,   0, ACT_SAME_HOP, 5'd0, 8'd0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_routes[i]) begin
      send_route(directed_routes[i].dest, directed_routes[i].hop,
                 directed_routes[i].distance, directed_routes[i].typed,
                 directed_routes[i].want);
    end
    hold_until_drained();

    // Most requests re-advertise a known destination so that the same hop,
    // improved and kept paths are hit often; new destinations fill the table
    // and then run into the full case.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > 0 && n % PAUSE_EVERY == 0) hold_until_drained();
      mode = $urandom_range(0, 99);
      if (shadow_count == 0 || mode < 25) begin
        r_dest = $urandom();
        r_hop  = $urandom_range(0, 1) ? hop_pool[$urandom_range(0, 3)] : $urandom();
        r_dist = $urandom_range(0, 255);
      end else begin
        slot   = $urandom_range(0, shadow_count - 1);
        r_dest = 32'(shadow_dest[slot]);
        base   = shadow_dist[slot];
        if ($urandom_range(0, 99) < 35) begin
          r_hop = 32'(shadow_hop[slot]);
        end else begin
          r_hop = $urandom_range(0, 1) ? hop_pool[$urandom_range(0, 3)] : $urandom();
        end
        case ($urandom_range(0, 3))
          0: r_dist = base;
          1: r_dist = base - 8'd1;
          2: r_dist = base + 8'd1;
          default: r_dist = $urandom_range(0, 255);
        endcase
      end
      send_route(r_dest, r_hop, r_dist, 1'b0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
